FILE: rtl/mep_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mep_pkg;

  // Q4.28 fixed point
  localparam int Q_FRAC = 28;
  localparam int MAX_DIM = 4096;

  localparam int COORD_W = 12;
  localparam int COUNT_W = 16;
  localparam int GRAY_W = 24;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int DIVIDEND_W = 40;

  localparam logic [GRAY_W-1:0] GRAY_FULL = 24'hFF_FFFF;
  // 4.0 in Q8.56
  localparam logic [63:0] ESCAPE_SQ = 64'h0400_0000_0000_0000;

  localparam logic signed [63:0] Q_MAX = 64'sd2147483647;
  localparam logic signed [63:0] Q_MIN = -64'sd2147483648;

  localparam logic signed [31:0] X_ORIGIN_RST = -32'sd1073741824;
  localparam logic signed [31:0] Y_ORIGIN_RST = -32'sd1073741824;
  localparam logic signed [31:0] X_STEP_RST = 32'sd1073742;
  localparam logic signed [31:0] Y_STEP_RST = 32'sd1073742;
  localparam logic [COUNT_W-1:0] MAX_ITER_RST = 16'd1000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_X_ORIGIN = 3'd0,
    REG_Y_ORIGIN = 3'd1,
    REG_X_STEP   = 3'd2,
    REG_Y_STEP   = 3'd3,
    REG_MAX_ITER = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
  } pixel_t;

  typedef struct packed {
    logic [COUNT_W-1:0] iteration_count;
    logic [GRAY_W-1:0]  gray_color;
  } escape_t;

  function automatic logic [COORD_W-1:0] clamp_index(input logic [COORD_W-1:0] v);
    if (int'(v) >= MAX_DIM) begin
      return COORD_W'(MAX_DIM - 1);
    end
    return v;
  endfunction

  function automatic logic signed [31:0] sat_q(input logic signed [63:0] v);
    if (v > Q_MAX) begin
      return 32'sh7FFF_FFFF;
    end
    if (v < Q_MIN) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [63:0] sext_q(input logic signed [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/mep_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mep_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/mandelbrot_escape_pixel.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   | dir | payload                          | transfer when
// ----------+-----+----------------------------------+---------------------------
// pixel     | in  | column[11:0], row[11:0]          | pixel.valid & pixel.ready
// result    | out | iteration_count[15:0], gray[23:0]| result.valid & result.ready
// cfg       | in  | cfg_index[2:0], cfg_data[31:0]   | cfg_write
//
// each pixel uses the single 32x32 multiplier three times per iteration plus
// an update step, then a 40-step restoring divider forms the gray level.
// pixel.ready is high only while the sequencer is idle; result is held in an
// output register, so a new pixel is taken while a result waits.
// rst is synchronous and clears the sequencer, the output valid and the
// configuration registers to their defaults.

module mandelbrot_escape_pixel
  import mep_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  mep_stream_if.sink                  pixel,
  mep_stream_if.source                result
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MCX,
    S_MCY,
    S_SETY,
    S_XX,
    S_YY,
    S_XY,
    S_UPD,
    S_GMUL,
    S_DINIT,
    S_DIV,
    S_DONE
  } state_t;

  state_t state;

  logic signed [31:0]     x_origin;
  logic signed [31:0]     y_origin;
  logic signed [31:0]     x_step;
  logic signed [31:0]     y_step;
  logic [COUNT_W-1:0]     max_iterations;

  logic [COORD_W-1:0]     col_q;
  logic [COORD_W-1:0]     row_q;
  logic [COUNT_W-1:0]     count;
  logic signed [31:0]     cx;
  logic signed [31:0]     cy;
  logic signed [31:0]     zx;
  logic signed [31:0]     zy;
  logic signed [63:0]     xx;
  logic signed [63:0]     diff;
  logic signed [63:0]     prod;
  logic signed [31:0]     mul_a;
  logic signed [31:0]     mul_b;
  logic [COUNT_W-1:0]     rem;
  logic [DIVIDEND_W-1:0]  quo;
  logic [5:0]             bit_cnt;
  logic [COUNT_W:0]       shifted;
  logic                   fits;
  logic                   escaped;
  logic                   out_valid;
  escape_t                out_data;

  assign pixel.ready  = (state == S_IDLE);
  assign result.valid = out_valid;
  assign result.data  = out_data;

  // sum of squares is non-negative and at most 2^63, compared unsigned
  assign escaped = (64'(xx) + 64'(prod)) > ESCAPE_SQ;
  assign shifted = {rem, quo[DIVIDEND_W-1]};
  assign fits    = shifted >= {1'b0, max_iterations};

  // shared multiplier operand select
  always_comb begin
    mul_a = zx;
    mul_b = zx;
    unique case (state)
      S_MCX:  begin mul_a = signed'(32'(col_q)); mul_b = x_step; end
      S_MCY:  begin mul_a = signed'(32'(row_q)); mul_b = y_step; end
      S_YY:   begin mul_a = zy; mul_b = zy; end
      S_XY:   begin mul_a = zx; mul_b = zy; end
      S_GMUL: begin mul_a = signed'(32'(count)); mul_b = signed'(32'(GRAY_FULL)); end
      default: begin mul_a = zx; mul_b = zx; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_origin       <= X_ORIGIN_RST;
      y_origin       <= Y_ORIGIN_RST;
      x_step         <= X_STEP_RST;
      y_step         <= Y_STEP_RST;
      max_iterations <= MAX_ITER_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_X_ORIGIN: x_origin <= signed'(cfg_data);
        REG_Y_ORIGIN: y_origin <= signed'(cfg_data);
        REG_X_STEP:   x_step <= signed'(cfg_data);
        REG_Y_STEP:   y_step <= signed'(cfg_data);
        REG_MAX_ITER: max_iterations <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!out_valid || result.ready)) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pixel.valid) begin
            col_q <= clamp_index(pixel.data.column);
            row_q <= clamp_index(pixel.data.row);
            state <= S_MCX;
          end
        end
        S_MCX: state <= S_MCY;
        S_MCY: begin
          cx    <= sat_q(sext_q(x_origin) + prod);
          zx    <= sat_q(sext_q(x_origin) + prod);
          state <= S_SETY;
        end
        S_SETY: begin
          cy    <= sat_q(sext_q(y_origin) + prod);
          zy    <= sat_q(sext_q(y_origin) + prod);
          count <= '0;
          state <= S_XX;
        end
        S_XX: begin
          state <= (count < max_iterations) ? S_YY : S_GMUL;
        end
        S_YY: begin
          xx    <= prod;
          state <= S_XY;
        end
        S_XY: begin
          // prod holds y*y here
          diff  <= xx - prod;
          state <= escaped ? S_GMUL : S_UPD;
        end
        S_UPD: begin
          // arithmetic shifts round toward minus infinity
          zx    <= sat_q((diff >>> Q_FRAC) + sext_q(cx));
          zy    <= sat_q((prod >>> (Q_FRAC - 1)) + sext_q(cy));
          count <= count + 1'b1;
          state <= S_XX;
        end
        S_GMUL: state <= S_DINIT;
        S_DINIT: begin
          quo     <= prod[DIVIDEND_W-1:0];
          rem     <= '0;
          bit_cnt <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          if (fits) begin
            rem <= COUNT_W'(shifted - {1'b0, max_iterations});
          end else begin
            rem <= shifted[COUNT_W-1:0];
          end
          quo     <= {quo[DIVIDEND_W-2:0], fits};
          bit_cnt <= bit_cnt + 1'b1;
          if (bit_cnt == 6'(DIVIDEND_W - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || result.ready) begin
            out_data.iteration_count <= count;
            out_data.gray_color <= (max_iterations == '0) ? '0 : quo[GRAY_W-1:0];
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_XX || state == S_YY || state == S_XY || state == S_UPD)
      |-> count <= max_iterations)
    else $error("iteration count beyond limit");

  a_result_bound: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.data.iteration_count <= max_iterations)
    else $error("result count beyond limit");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && max_iterations != '0) |-> rem < max_iterations)
    else $error("divider remainder out of range");

  a_quo_fits: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && max_iterations != '0) |-> quo[DIVIDEND_W-1:GRAY_W] == '0)
    else $error("gray quotient overflow");

  a_take_when_idle: assert property (@(posedge clk) disable iff (rst)
    (pixel.valid && pixel.ready) |=> state == S_MCX)
    else $error("pixel transfer did not start sequencer");
`endif

endmodule

`default_nettype wire

FILE: verif/mandelbrot_escape_pixel_test.sv
`timescale 1ns / 1ps

module mandelbrot_escape_pixel_test;
  import mep_pkg::*;

  localparam logic [31:0] Q_ONE = 32'sd268435456;
  localparam logic [31:0] Q_TOP = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_BOTTOM = 32'h8000_0000;
  localparam int HOLD_CYCLES = 3000;

  // expected escape results, worked out from the pixel and the current register set
  class escape_tally;
    logic signed [31:0] x_origin;
    logic signed [31:0] y_origin;
    logic signed [31:0] x_step;
    logic signed [31:0] y_step;
    logic [COUNT_W-1:0] limit;
    escape_t owed[$];
    int errors;

    function new();
      x_origin = X_ORIGIN_RST;
      y_origin = Y_ORIGIN_RST;
      x_step = X_STEP_RST;
      y_step = Y_STEP_RST;
      limit = MAX_ITER_RST;
      errors = 0;
    endfunction

    function void set_reg(reg_index_t idx, logic [31:0] v);
      case (idx)
        REG_X_ORIGIN: x_origin = v;
        REG_Y_ORIGIN: y_origin = v;
        REG_X_STEP: x_step = v;
        REG_Y_STEP: y_step = v;
        REG_MAX_ITER: limit = v[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clip_q(longint v);
      if (v > Q_MAX) return Q_MAX;
      if (v < Q_MIN) return Q_MIN;
      return v;
    endfunction

    function void take_pixel(pixel_t p);
      longint col, row, cx, cy, zx, zy, xx, yy, xy;
      longint unsigned mag, shade;
      int unsigned count;
      escape_t e;
      col = p.column;
      row = p.row;
      if (col >= MAX_DIM) col = MAX_DIM - 1;
      if (row >= MAX_DIM) row = MAX_DIM - 1;
      cx = clip_q(longint'(x_origin) + col * longint'(x_step));
      cy = clip_q(longint'(y_origin) + row * longint'(y_step));
      zx = cx;
      zy = cy;
      count = 0;
      while (count < limit) begin
        xx = zx * zx;
        yy = zy * zy;
        // Q8.56 magnitude, can reach 2^63 so kept unsigned
        mag = $unsigned(xx) + $unsigned(yy);
        if (mag > ESCAPE_SQ) break;
        xy = zx * zy;
        zx = clip_q(((xx - yy) >>> Q_FRAC) + cx);
        zy = clip_q((xy >>> (Q_FRAC - 1)) + cy);
        count++;
      end
      shade = 0;
      if (limit != 0) shade = 64'(GRAY_FULL) * 64'(count) / 64'(limit);
      e.iteration_count = count[COUNT_W-1:0];
      e.gray_color = shade[GRAY_W-1:0];
      owed.push_back(e);
    endfunction

    function void check_escape(escape_t got);
      escape_t want;
      if (owed.size() == 0) begin
        $error("result transfer with nothing expected: iteration_count %0d gray_color %06h",
               got.iteration_count, got.gray_color);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.iteration_count !== want.iteration_count) begin
        $error("iteration_count: expected %0d, actual %0d",
               want.iteration_count, got.iteration_count);
        errors++;
      end
      if (got.gray_color !== want.gray_color) begin
        $error("gray_color: expected %06h, actual %06h", want.gray_color, got.gray_color);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_write;
  reg_index_t cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int idle_pct = 0;
  int hold_asks = 0;
  escape_tally tally = new();

  mep_stream_if #(.payload_t(pixel_t)) pixels ();
  mep_stream_if #(.payload_t(escape_t)) escapes ();

  mandelbrot_escape_pixel dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pixel(pixels),
    .result(escapes)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #40_000_000;
    $display("mandelbrot_escape_pixel verification failed");
    $finish;
  end

  // receiving side: random back-pressure plus the occasional long hold
  initial begin : drain_results
    int stall;
    int holds_served;
    stall = 0;
    holds_served = 0;
    escapes.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (escapes.valid === 1'b1 && escapes.ready === 1'b1) tally.check_escape(escapes.data);
      if (holds_served != hold_asks) begin
        holds_served++;
        stall = HOLD_CYCLES;
      end else if (stall == 0 && idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
        stall = $urandom_range(1, 17);
      end
      if (stall > 0) begin
        escapes.ready <= 1'b0;
        stall--;
      end else begin
        escapes.ready <= 1'b1;
      end
    end
  end

  task automatic send_pixel(input int col, input int row);
    pixel_t p;
    p.column = COORD_W'(col);
    p.row = COORD_W'(row);
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      pixels.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    pixels.valid <= 1'b1;
    pixels.data <= p;
    do @(posedge clk); while (pixels.ready !== 1'b1);
    tally.take_pixel(p);
  endtask

  // block is idle once every owed result has come back
  task automatic drain();
    pixels.valid <= 1'b0;
    while (tally.owed.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    tally.set_reg(idx, value);
  endtask

  task automatic configure(input logic [31:0] xo, input logic [31:0] yo,
                           input logic [31:0] xs, input logic [31:0] ys,
                           input int lim);
    drain();
    write_reg(REG_X_ORIGIN, xo);
    write_reg(REG_Y_ORIGIN, yo);
    write_reg(REG_X_STEP, xs);
    write_reg(REG_Y_STEP, ys);
    // upper bits of the limit write are don't-care
    write_reg(REG_MAX_ITER, {16'($urandom), COUNT_W'(lim)});
    cfg_write <= 1'b0;
  endtask

  initial begin : stimulus
    int xo, yo, xs, ys, k, r;
    int lim;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_X_ORIGIN;
    cfg_data = '0;
    pixels.valid = 1'b0;
    pixels.data = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset register set: corners at column 4095 saturate, (-1,0) and ~0 stay bounded
    idle_pct = 20;
    send_pixel(0, 0);
    send_pixel(MAX_DIM - 1, MAX_DIM - 1);
    send_pixel(750, 1000);
    send_pixel(1000, 1000);
    send_pixel(MAX_DIM - 1, 0);

    // zero limit
    configure($urandom, $urandom, $urandom, $urandom, 0);
    send_pixel(0, 0);
    send_pixel(MAX_DIM - 1, MAX_DIM - 1);

    // origin and step extremes, point saturates outside the radius
    configure(Q_TOP, Q_BOTTOM, Q_TOP, Q_BOTTOM, 65535);
    send_pixel(0, 0);
    send_pixel(MAX_DIM - 1, MAX_DIM - 1);
    send_pixel(MAX_DIM - 1, 0);
    send_pixel(0, MAX_DIM - 1);

    // c = 0 runs the full limit once
    configure(0, 0, Q_BOTTOM, Q_TOP, 65535);
    send_pixel(0, 0);
    send_pixel(1, 0);
    send_pixel(MAX_DIM - 1, MAX_DIM - 1);

    configure(0, 0, 0, 0, 1);
    send_pixel(0, 0);
    send_pixel(MAX_DIM - 1, MAX_DIM - 1);

    // |z|^2 landing exactly on 4: c = -2 sticks at 2, c = 2 and c = 2i escape next
    configure(-2 * Q_ONE, 0, Q_ONE, Q_ONE, 64);
    send_pixel(0, 0);
    send_pixel(1, 0);
    send_pixel(2, 0);
    send_pixel(3, 0);
    send_pixel(4, 0);
    send_pixel(2, 2);

    for (int ph = 0; ph < 12; ph++) begin
      r = $urandom_range(0, 19);
      if (r == 0) lim = 0;
      else if (r < 4) lim = $urandom_range(1, 4);
      else lim = $urandom_range(5, 96);
      if ($urandom_range(0, 9) == 0) begin
        xo = $urandom;
        yo = $urandom;
        xs = $urandom;
        ys = $urandom;
      end else begin
        // window over the interesting part of the plane
        xo = -671088640 + int'($urandom_range(0, 939524096));
        yo = -402653184 + int'($urandom_range(0, 536870912));
        k = $urandom_range(4, 18);
        xs = $urandom_range(1, 1 << k);
        k = $urandom_range(4, 18);
        ys = $urandom_range(1, 1 << k);
        if ($urandom_range(0, 3) == 0) xs = -xs;
        if ($urandom_range(0, 3) == 0) ys = -ys;
      end
      configure(xo, yo, xs, ys, lim);
      if (ph >= 10) begin
        idle_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 15;
          default: idle_pct = 45;
        endcase
      end
      if (ph == 3 || ph == 7) hold_asks++;
      repeat (50) send_pixel($urandom_range(0, MAX_DIM - 1), $urandom_range(0, MAX_DIM - 1));
    end

    drain();
    repeat (64) @(posedge clk);
    if (tally.owed.size() != 0) begin
      $error("%0d results never arrived", tally.owed.size());
      tally.errors++;
    end
    if (tally.errors == 0) begin
      $display("mandelbrot_escape_pixel verification clean");
    end else begin
      $display("mandelbrot_escape_pixel verification failed");
    end
    $finish;
  end

endmodule
